>>> hdl/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types and codes for the buddy page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int TAG_W = 5;
  localparam logic [TAG_W-1:0] NO_TAG = 5'd31;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_ADD   = 2'd2,
    CMD_NONE  = 2'd3
  } bpa_cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OOM   = 2'd1,
    ST_ORDER = 2'd2,
    ST_PAGE0 = 2'd3
  } bpa_status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_AL_RD,
    S_AL_POP,
    S_AL_POP2,
    S_SPLIT,
    S_PUSH_A,
    S_PUSH_B,
    S_FR_CHK,
    S_FR_RD,
    S_FR_CLR,
    S_ADD,
    S_DONE
  } bpa_state_e;

  typedef struct packed {
    bpa_cmd_e    cmd;
    logic [11:0] page;
    logic [3:0]  order;
    logic [12:0] region_len;
  } bpa_in_t;

  typedef struct packed {
    bpa_status_e status;
    logic [11:0] block_page;
    logic [12:0] free_count;
    logic [12:0] total_count;
  } bpa_out_t;

endpackage

>>> hdl/bpa_ram.sv
// ----------------------------------------------------------------------------
// bpa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/buddy_page_allocator.sv
// ----------------------------------------------------------------------------
// buddy_page_allocator
// Binary buddy page allocator with per-order LIFO free lists kept in RAM.
// ----------------------------------------------------------------------------
// After reset the block sweeps every entry of its free-block tag RAM with
// busy_o high; configuration writes are taken during that time. An item is
// taken when start_i is high and busy_o is low, and its single result shows
// on res_o for one cycle with done_o high; the receiver cannot stall it, so
// sample it then. Each item runs through a sequencer around the link and tag
// RAMs (one write port and one read port per RAM, registered read data).
// Allocate pops a block of the smallest free order that fits and splits it
// down one order at a time, free merges with its buddy order by order, add
// region inserts aligned blocks, and a rejected item goes straight to the
// result. The number of splits, merges and inserted blocks sets the time;
// busy_o drops in the cycle after the result.
// ----------------------------------------------------------------------------
module buddy_page_allocator #(
  parameter int PAGES     = 4096,
  parameter int MAX_ORDER = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [12:0]      cfg_wdata_i,
  input  logic             start_i,
  input  bpa_pkg::bpa_in_t req_i,
  output logic             busy_o,
  output logic             done_o,
  output bpa_pkg::bpa_out_t res_o
);
  import bpa_pkg::*;

  localparam int AW = $clog2(PAGES);
  localparam int CW = AW + 1;
  localparam int OW = $clog2(MAX_ORDER + 1);
  localparam int MX = (AW > MAX_ORDER) ? AW : MAX_ORDER;
  localparam int WW = ((MX > 13) ? MX : 13) + 2;
  localparam logic [CW-1:0] NIL = CW'(PAGES);
  localparam logic [WW-1:0] PAGES_W = WW'(PAGES);

  bpa_state_e state_q, state_d;
  bpa_cmd_e cmd_q, cmd_d;
  bpa_status_e status_q, status_d;
  logic [3:0] order_q, order_d;
  logic [OW-1:0] o_q, o_d, push_o_q, push_o_d;
  logic [AW-1:0] b_q, b_d, bud_q, bud_d, push_b_q, push_b_d, clr_q, clr_d;
  logic [CW-1:0] push_h_q, push_h_d, free_q, free_d, total_q, total_d;
  logic [WW-1:0] a_q, a_d, rend_q, rend_d, added_q, added_d;
  logic [11:0] blk_q, blk_d;
  logic [12:0] mem_pages_q;
  logic [CW-1:0] heads_q [MAX_ORDER+1];
  logic [CW-1:0] heads_d [MAX_ORDER+1];

  logic tag_we, next_we, prev_we;
  logic [AW-1:0] tag_waddr, next_waddr, prev_waddr, raddr;
  logic [TAG_W-1:0] tag_wdata, tag_rdata;
  logic [CW-1:0] next_wdata, prev_wdata, next_rdata, prev_rdata;

  logic [WW-1:0] top, sz_o, bud, psz, rem, asz, req_sz, free_end, reg_end;
  logic [OW-1:0] found_o, add_o;
  logic found_any, ord_big, fr_stop, add_more, split_more;
  logic [CW-1:0] h_cur;

  function automatic logic [CW-1:0] sat_add(logic [CW-1:0] v, logic [WW-1:0] n);
    logic [WW-1:0] t;
    t = WW'(v) + n;
    return (t > PAGES_W) ? NIL : CW'(t);
  endfunction

  function automatic logic [CW-1:0] sat_sub(logic [CW-1:0] v, logic [WW-1:0] n);
    return (n > WW'(v)) ? '0 : CW'(WW'(v) - n);
  endfunction

  assign top = (WW'(mem_pages_q) < PAGES_W) ? WW'(mem_pages_q) : PAGES_W;
  assign sz_o = WW'(1) << o_q;
  assign bud = WW'(b_q) ^ sz_o;
  assign psz = WW'(1) << push_o_q;
  assign rem = rend_q - a_q;
  assign asz = WW'(1) << add_o;
  assign req_sz = WW'(1) << req_i.order;
  assign free_end = WW'(req_i.page) + req_sz;
  assign reg_end = (WW'(req_i.page) + WW'(req_i.region_len) > top) ? top :
                   WW'(req_i.page) + WW'(req_i.region_len);
  assign ord_big = int'(req_i.order) > MAX_ORDER;
  assign fr_stop = (int'(o_q) >= MAX_ORDER) || (bud + sz_o > top) || (bud >= PAGES_W);
  assign add_more = a_q < rend_q;
  assign split_more = 5'(o_q) > 5'(order_q);
  assign h_cur = heads_q[push_o_q];

  always_comb begin
    found_any = 1'b0;
    found_o = '0;
    for (int k = MAX_ORDER; k >= 0; k--) begin
      if (heads_q[k] != NIL && k >= int'(req_i.order)) begin
        found_any = 1'b1;
        found_o = OW'(k);
      end
    end
  end

  always_comb begin
    add_o = '0;
    for (int k = 1; k <= MAX_ORDER; k++) begin
      if ((a_q & ((WW'(1) << k) - WW'(1))) == '0 && rem >= (WW'(1) << k)) begin
        add_o = OW'(k);
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_q == AW'(PAGES - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          case (req_i.cmd)
            CMD_ALLOC: begin
              state_d = (ord_big || !found_any) ? S_DONE : S_AL_RD;
            end
            CMD_FREE: begin
              state_d = (ord_big || free_end > top || req_i.page == '0) ? S_DONE : S_FR_CHK;
            end
            CMD_ADD: state_d = S_ADD;
            default: state_d = S_DONE;
          endcase
        end
      end
      S_AL_RD:   state_d = S_AL_POP;
      S_AL_POP:  state_d = S_AL_POP2;
      S_AL_POP2: state_d = S_SPLIT;
      S_SPLIT:   state_d = split_more ? S_PUSH_A : S_DONE;
      S_PUSH_A: begin
        if (h_cur < NIL) begin
          state_d = S_PUSH_B;
        end else begin
          case (cmd_q)
            CMD_ALLOC: state_d = S_SPLIT;
            CMD_ADD:   state_d = S_ADD;
            default:   state_d = S_DONE;
          endcase
        end
      end
      S_PUSH_B: begin
        case (cmd_q)
          CMD_ALLOC: state_d = S_SPLIT;
          CMD_ADD:   state_d = S_ADD;
          default:   state_d = S_DONE;
        endcase
      end
      S_FR_CHK: state_d = fr_stop ? S_PUSH_A : S_FR_RD;
      S_FR_RD:  state_d = (tag_rdata != TAG_W'(o_q)) ? S_PUSH_A : S_FR_CLR;
      S_FR_CLR: state_d = S_FR_CHK;
      S_ADD:    state_d = add_more ? S_PUSH_A : S_DONE;
      S_DONE:   state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    cmd_d = cmd_q;
    status_d = status_q;
    order_d = order_q;
    o_d = o_q;
    push_o_d = push_o_q;
    b_d = b_q;
    bud_d = bud_q;
    push_b_d = push_b_q;
    push_h_d = push_h_q;
    clr_d = clr_q;
    free_d = free_q;
    total_d = total_q;
    a_d = a_q;
    rend_d = rend_q;
    added_d = added_q;
    blk_d = blk_q;
    heads_d = heads_q;
    tag_we = 1'b0;
    tag_waddr = '0;
    tag_wdata = NO_TAG;
    next_we = 1'b0;
    next_waddr = '0;
    next_wdata = NIL;
    prev_we = 1'b0;
    prev_waddr = '0;
    prev_wdata = NIL;
    raddr = '0;
    case (state_q)
      S_CLEAR: begin
        tag_we = 1'b1;
        tag_waddr = clr_q;
        clr_d = clr_q + AW'(1);
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_d = req_i.cmd;
          order_d = req_i.order;
          status_d = ST_OK;
          blk_d = '0;
          case (req_i.cmd)
            CMD_ALLOC: begin
              if (ord_big) begin
                status_d = ST_ORDER;
              end else if (!found_any) begin
                status_d = ST_OOM;
              end else begin
                o_d = found_o;
                b_d = heads_q[found_o][AW-1:0];
              end
            end
            CMD_FREE: begin
              if (ord_big || free_end > top) begin
                status_d = ST_ORDER;
              end else if (req_i.page == '0) begin
                status_d = ST_PAGE0;
              end else begin
                b_d = AW'(req_i.page);
                o_d = OW'(req_i.order);
                free_d = sat_add(free_q, req_sz);
              end
            end
            CMD_ADD: begin
              a_d = WW'(req_i.page);
              rend_d = reg_end;
              added_d = '0;
            end
            default: ;
          endcase
        end
      end
      S_AL_RD: raddr = b_q;
      S_AL_POP: begin
        heads_d[o_q] = next_rdata;
        if (next_rdata < NIL) begin
          prev_we = 1'b1;
          prev_waddr = next_rdata[AW-1:0];
        end
        next_we = 1'b1;
        next_waddr = b_q;
        tag_we = 1'b1;
        tag_waddr = b_q;
        free_d = sat_sub(free_q, sz_o);
        blk_d = 12'(b_q);
      end
      S_AL_POP2: begin
        prev_we = 1'b1;
        prev_waddr = b_q;
      end
      S_SPLIT: begin
        if (split_more) begin
          o_d = o_q - OW'(1);
          push_o_d = o_q - OW'(1);
          push_b_d = b_q + AW'(sz_o >> 1);
        end
      end
      S_PUSH_A: begin
        next_we = 1'b1;
        next_waddr = push_b_q;
        next_wdata = h_cur;
        prev_we = 1'b1;
        prev_waddr = push_b_q;
        tag_we = 1'b1;
        tag_waddr = push_b_q;
        tag_wdata = TAG_W'(push_o_q);
        heads_d[push_o_q] = CW'(push_b_q);
        push_h_d = h_cur;
        if (cmd_q != CMD_FREE) free_d = sat_add(free_q, psz);
      end
      S_PUSH_B: begin
        prev_we = 1'b1;
        prev_waddr = push_h_q[AW-1:0];
        prev_wdata = CW'(push_b_q);
      end
      S_FR_CHK: begin
        if (fr_stop) begin
          push_b_d = b_q;
          push_o_d = o_q;
        end else begin
          raddr = bud[AW-1:0];
          bud_d = bud[AW-1:0];
        end
      end
      S_FR_RD: begin
        if (tag_rdata != TAG_W'(o_q)) begin
          push_b_d = b_q;
          push_o_d = o_q;
        end else begin
          if (prev_rdata < NIL) begin
            next_we = 1'b1;
            next_waddr = prev_rdata[AW-1:0];
            next_wdata = next_rdata;
          end else begin
            heads_d[o_q] = next_rdata;
          end
          if (next_rdata < NIL) begin
            prev_we = 1'b1;
            prev_waddr = next_rdata[AW-1:0];
            prev_wdata = prev_rdata;
          end
          tag_we = 1'b1;
          tag_waddr = bud_q;
        end
      end
      S_FR_CLR: begin
        next_we = 1'b1;
        next_waddr = bud_q;
        prev_we = 1'b1;
        prev_waddr = bud_q;
        if (bud_q < b_q) b_d = bud_q;
        o_d = o_q + OW'(1);
      end
      S_ADD: begin
        if (add_more) begin
          push_b_d = a_q[AW-1:0];
          push_o_d = add_o;
          a_d = a_q + asz;
          added_d = added_q + asz;
        end else begin
          total_d = sat_add(total_q, added_q);
        end
      end
      S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q <= '0;
      free_q <= '0;
      total_q <= '0;
      mem_pages_q <= 13'(PAGES);
      for (int k = 0; k <= MAX_ORDER; k++) heads_q[k] <= NIL;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      free_q <= free_d;
      total_q <= total_d;
      if (cfg_we_i) mem_pages_q <= cfg_wdata_i;
      heads_q <= heads_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    status_q <= status_d;
    order_q <= order_d;
    o_q <= o_d;
    push_o_q <= push_o_d;
    b_q <= b_d;
    bud_q <= bud_d;
    push_b_q <= push_b_d;
    push_h_q <= push_h_d;
    a_q <= a_d;
    rend_q <= rend_d;
    added_q <= added_d;
    blk_q <= blk_d;
  end

  bpa_ram #(.WIDTH(TAG_W), .DEPTH(PAGES)) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (tag_waddr),
    .wdata_i (tag_wdata),
    .raddr_i (raddr),
    .rdata_o (tag_rdata)
  );

  bpa_ram #(.WIDTH(CW), .DEPTH(PAGES)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (next_we),
    .waddr_i (next_waddr),
    .wdata_i (next_wdata),
    .raddr_i (raddr),
    .rdata_o (next_rdata)
  );

  bpa_ram #(.WIDTH(CW), .DEPTH(PAGES)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prev_we),
    .waddr_i (prev_waddr),
    .wdata_i (prev_wdata),
    .raddr_i (raddr),
    .rdata_o (prev_rdata)
  );

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);
  assign res_o.status = status_q;
  assign res_o.block_page = blk_q;
  assign res_o.free_count = 13'(free_q);
  assign res_o.total_count = 13'(total_q);

`ifndef NO_ASSERTIONS
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("item taken but block not busy");
  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= NIL) else $error("free page count above page total");
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= NIL) else $error("managed page count above page total");
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FR_CHK) |-> !tag_we) else $error("tag write during buddy lookup");
`endif

endmodule
